// ----- design/lfk_pkg.sv -----
// ----------------------------------------------------------------------------
// lfk_pkg: shared types and constants of the leg forward kinematics unit
// Fixed-point formats, joint bounds, polynomial coefficients and the rounded
// Q24 product used by the joint and trigonometry pipelines.
// ----------------------------------------------------------------------------
package lfk_pkg;

	localparam int ANGLE_WIDTH = 16;
	localparam int ANGLE_FRAC  = 13;
	localparam int QF          = 24;
	localparam int COEF_W      = 26;
	localparam int Q_W         = 27;
	localparam int WIDE_W      = 56;
	localparam int FOOT_W      = 19;
	localparam int NJ          = 3;

	typedef logic signed [ANGLE_WIDTH-1:0]        angle_t;
	typedef logic signed [COEF_W-1:0]             coef_t;
	typedef logic signed [COEF_W+ANGLE_WIDTH-1:0] prod_t;
	typedef logic signed [Q_W-1:0]                q_t;
	typedef logic signed [WIDE_W-1:0]             wide_t;
	typedef logic signed [FOOT_W-1:0]             foot_t;

	typedef struct packed {
		logic valid;
		logic in_range;
	} ctrl_t;

	localparam angle_t LIM_LO [NJ] = '{angle_t'(-6068), angle_t'(-5035), angle_t'(-12867)};
	localparam angle_t LIM_HI [NJ] = '{angle_t'(12867), angle_t'(12867), angle_t'(10199)};

	localparam coef_t Y0 [NJ] = '{coef_t'(-5975447), coef_t'(-7294442), coef_t'(2010752)};
	localparam coef_t MS [NJ] = '{coef_t'(14582336), coef_t'(15427689), coef_t'(11960792)};
	localparam coef_t A0 [NJ] = '{coef_t'(-232683), coef_t'(2751231), coef_t'(837335)};
	localparam coef_t A1 [NJ] = '{coef_t'(6136104), coef_t'(6701209), coef_t'(11748947)};
	localparam coef_t A2 [NJ] = '{coef_t'(846134), coef_t'(838093), coef_t'(-41406)};
	localparam coef_t A3 [NJ] = '{coef_t'(-1302618), coef_t'(-1294457), coef_t'(2760006)};

	localparam q_t ONE_Q = q_t'(1) <<< QF;

	function automatic q_t mulq(input wide_t prod);
		return q_t'((prod + (wide_t'(1) <<< (QF - 1))) >>> QF);
	endfunction

endpackage

// ----- design/lfk_if.sv -----
// ----------------------------------------------------------------------------
// lfk_if: channel interfaces of the leg forward kinematics unit
// Valid/ready channels for the servo angle input and the foot position output.
// ----------------------------------------------------------------------------
interface lfk_angle_if;
	logic            valid;
	logic            ready;
	lfk_pkg::angle_t motor_angle_base;
	lfk_pkg::angle_t motor_angle_upper;
	lfk_pkg::angle_t motor_angle_lower;

	modport source (output valid, output motor_angle_base, output motor_angle_upper,
		output motor_angle_lower, input ready);
	modport sink (input valid, input motor_angle_base, input motor_angle_upper,
		input motor_angle_lower, output ready);
endinterface

interface lfk_foot_if;
	logic           valid;
	logic           ready;
	logic           in_range;
	lfk_pkg::foot_t foot_x;
	lfk_pkg::foot_t foot_y;
	lfk_pkg::foot_t foot_z;

	modport source (output valid, output in_range, output foot_x, output foot_y,
		output foot_z, input ready);
	modport sink (input valid, input in_range, input foot_x, input foot_y,
		input foot_z, output ready);
endinterface

// ----- design/lfk_joint.sv -----
// ----------------------------------------------------------------------------
// lfk_joint: servo angle to joint angle pipeline
// Five stages: bounds check and scale, offset, square, cube and partial
// products, cubic sum. Three joints run side by side.
// ----------------------------------------------------------------------------
module lfk_joint (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  lfk_pkg::angle_t angle [lfk_pkg::NJ],
	output lfk_pkg::ctrl_t  ctrl_out,
	output lfk_pkg::q_t     q [lfk_pkg::NJ]
);

	logic [lfk_pkg::NJ-1:0] in_bound;
	lfk_pkg::ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	lfk_pkg::prod_t prod_s1 [lfk_pkg::NJ];
	lfk_pkg::q_t    u_s2 [lfk_pkg::NJ];
	lfk_pkg::q_t    u_s3 [lfk_pkg::NJ];
	lfk_pkg::q_t    u2_s3 [lfk_pkg::NJ];
	lfk_pkg::q_t    u3_s4 [lfk_pkg::NJ];
	lfk_pkg::q_t    p1_s4 [lfk_pkg::NJ];
	lfk_pkg::q_t    p2_s4 [lfk_pkg::NJ];
	lfk_pkg::q_t    q_s5 [lfk_pkg::NJ];

	always_comb begin
		for (int i = 0; i < lfk_pkg::NJ; i++) begin
			in_bound[i] = (angle[i] >= lfk_pkg::LIM_LO[i]) && (angle[i] <= lfk_pkg::LIM_HI[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
		end else if (en) begin
			ctrl_s1 <= '{valid: valid_in, in_range: &in_bound};
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < lfk_pkg::NJ; i++) begin
				prod_s1[i] <= lfk_pkg::prod_t'(lfk_pkg::MS[i]) * lfk_pkg::prod_t'(angle[i]);
				u_s2[i] <= lfk_pkg::q_t'(lfk_pkg::Y0[i]) + lfk_pkg::q_t'((prod_s1[i]
					+ (lfk_pkg::prod_t'(1) <<< (lfk_pkg::ANGLE_FRAC - 1))) >>> lfk_pkg::ANGLE_FRAC);
				u_s3[i] <= u_s2[i];
				u2_s3[i] <= lfk_pkg::mulq(lfk_pkg::wide_t'(u_s2[i]) * lfk_pkg::wide_t'(u_s2[i]));
				u3_s4[i] <= lfk_pkg::mulq(lfk_pkg::wide_t'(u2_s3[i]) * lfk_pkg::wide_t'(u_s3[i]));
				p1_s4[i] <= lfk_pkg::mulq(lfk_pkg::wide_t'(lfk_pkg::A1[i])
					* lfk_pkg::wide_t'(u_s3[i]));
				p2_s4[i] <= lfk_pkg::mulq(lfk_pkg::wide_t'(lfk_pkg::A2[i])
					* lfk_pkg::wide_t'(u2_s3[i]));
				q_s5[i] <= lfk_pkg::q_t'(lfk_pkg::A0[i]) + p1_s4[i] + p2_s4[i]
					+ lfk_pkg::mulq(lfk_pkg::wide_t'(lfk_pkg::A3[i]) * lfk_pkg::wide_t'(u3_s4[i]));
			end
		end
	end

	assign ctrl_out = ctrl_s5;
	assign q = q_s5;

	// Joint angles of poses within bounds stay inside one radian.
	a_q_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s5.valid && ctrl_s5.in_range |->
			q_s5[0] < lfk_pkg::ONE_Q && q_s5[0] > -lfk_pkg::ONE_Q &&
			q_s5[1] < lfk_pkg::ONE_Q && q_s5[1] > -lfk_pkg::ONE_Q &&
			q_s5[2] < lfk_pkg::ONE_Q && q_s5[2] > -lfk_pkg::ONE_Q)
		else $error("joint angle out of expected range");

endmodule

// ----- design/lfk_trig.sv -----
// ----------------------------------------------------------------------------
// lfk_trig: sine and cosine pipeline
// Nine stages of Horner evaluation, alternating a rounded product with a
// division by a constant done as a reciprocal multiply.
// ----------------------------------------------------------------------------
module lfk_trig (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  lfk_pkg::ctrl_t ctrl_in,
	input  lfk_pkg::q_t    q [lfk_pkg::NJ],
	output lfk_pkg::ctrl_t ctrl_out,
	output lfk_pkg::q_t    sin_q [lfk_pkg::NJ],
	output lfk_pkg::q_t    cos_q [lfk_pkg::NJ]
);

	localparam int TRIG_ST = 9;
	localparam int RCP_W   = 30;
	localparam int DIV_SH  = 32;

	typedef logic [lfk_pkg::QF:0]             uq_t;
	typedef logic [2*lfk_pkg::QF+1:0]         uwide_t;
	typedef logic [lfk_pkg::QF+RCP_W:0]       dwide_t;
	typedef logic [RCP_W-1:0]                 rcp_t;

	localparam uq_t  ONE_U  = uq_t'(1) << lfk_pkg::QF;
	localparam rcp_t RCP_72 = rcp_t'(((64'd1 << DIV_SH) + 64'd71) / 64'd72);
	localparam rcp_t RCP_42 = rcp_t'(((64'd1 << DIV_SH) + 64'd41) / 64'd42);
	localparam rcp_t RCP_20 = rcp_t'(((64'd1 << DIV_SH) + 64'd19) / 64'd20);
	localparam rcp_t RCP_6  = rcp_t'(((64'd1 << DIV_SH) + 64'd5) / 64'd6);
	localparam rcp_t RCP_90 = rcp_t'(((64'd1 << DIV_SH) + 64'd89) / 64'd90);
	localparam rcp_t RCP_56 = rcp_t'(((64'd1 << DIV_SH) + 64'd55) / 64'd56);
	localparam rcp_t RCP_30 = rcp_t'(((64'd1 << DIV_SH) + 64'd29) / 64'd30);
	localparam rcp_t RCP_12 = rcp_t'(((64'd1 << DIV_SH) + 64'd11) / 64'd12);

	function automatic uq_t mulu(input uq_t a, input uq_t b);
		return uq_t'(((uwide_t'(a) * uwide_t'(b)) + (uwide_t'(1) << (lfk_pkg::QF - 1)))
			>> lfk_pkg::QF);
	endfunction

	function automatic uq_t divk(input uq_t m, input rcp_t r);
		return uq_t'((dwide_t'(m) * dwide_t'(r)) >> DIV_SH);
	endfunction

	lfk_pkg::ctrl_t ctrl_s [TRIG_ST];
	lfk_pkg::q_t q_s1 [lfk_pkg::NJ], q_s2 [lfk_pkg::NJ], q_s3 [lfk_pkg::NJ], q_s4 [lfk_pkg::NJ];
	lfk_pkg::q_t q_s5 [lfk_pkg::NJ], q_s6 [lfk_pkg::NJ], q_s7 [lfk_pkg::NJ], q_s8 [lfk_pkg::NJ];
	uq_t t_s1 [lfk_pkg::NJ], t_s2 [lfk_pkg::NJ], t_s3 [lfk_pkg::NJ], t_s4 [lfk_pkg::NJ];
	uq_t t_s5 [lfk_pkg::NJ], t_s6 [lfk_pkg::NJ], t_s7 [lfk_pkg::NJ], t_s8 [lfk_pkg::NJ];
	uq_t ps_s2 [lfk_pkg::NJ], pc_s2 [lfk_pkg::NJ], ms_s3 [lfk_pkg::NJ], mc_s3 [lfk_pkg::NJ];
	uq_t ps_s4 [lfk_pkg::NJ], pc_s4 [lfk_pkg::NJ], ms_s5 [lfk_pkg::NJ], mc_s5 [lfk_pkg::NJ];
	uq_t ps_s6 [lfk_pkg::NJ], pc_s6 [lfk_pkg::NJ], ms_s7 [lfk_pkg::NJ], mc_s7 [lfk_pkg::NJ];
	uq_t ps_s8 [lfk_pkg::NJ], pc_s8 [lfk_pkg::NJ];
	lfk_pkg::q_t sin_s9 [lfk_pkg::NJ], cos_s9 [lfk_pkg::NJ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TRIG_ST; k++) begin
				ctrl_s[k] <= '0;
			end
		end else if (en) begin
			ctrl_s[0] <= ctrl_in;
			for (int k = 1; k < TRIG_ST; k++) begin
				ctrl_s[k] <= ctrl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < lfk_pkg::NJ; i++) begin
				t_s1[i] <= uq_t'(lfk_pkg::mulq(lfk_pkg::wide_t'(q[i]) * lfk_pkg::wide_t'(q[i])));
				q_s1[i] <= q[i];

				ps_s2[i] <= ONE_U - divk(t_s1[i], RCP_72);
				pc_s2[i] <= ONE_U - divk(t_s1[i], RCP_90);
				t_s2[i] <= t_s1[i];
				q_s2[i] <= q_s1[i];

				ms_s3[i] <= mulu(t_s2[i], ps_s2[i]);
				mc_s3[i] <= mulu(t_s2[i], pc_s2[i]);
				t_s3[i] <= t_s2[i];
				q_s3[i] <= q_s2[i];

				ps_s4[i] <= ONE_U - divk(ms_s3[i], RCP_42);
				pc_s4[i] <= ONE_U - divk(mc_s3[i], RCP_56);
				t_s4[i] <= t_s3[i];
				q_s4[i] <= q_s3[i];

				ms_s5[i] <= mulu(t_s4[i], ps_s4[i]);
				mc_s5[i] <= mulu(t_s4[i], pc_s4[i]);
				t_s5[i] <= t_s4[i];
				q_s5[i] <= q_s4[i];

				ps_s6[i] <= ONE_U - divk(ms_s5[i], RCP_20);
				pc_s6[i] <= ONE_U - divk(mc_s5[i], RCP_30);
				t_s6[i] <= t_s5[i];
				q_s6[i] <= q_s5[i];

				ms_s7[i] <= mulu(t_s6[i], ps_s6[i]);
				mc_s7[i] <= mulu(t_s6[i], pc_s6[i]);
				t_s7[i] <= t_s6[i];
				q_s7[i] <= q_s6[i];

				ps_s8[i] <= ONE_U - divk(ms_s7[i], RCP_6);
				pc_s8[i] <= ONE_U - divk(mc_s7[i], RCP_12);
				t_s8[i] <= t_s7[i];
				q_s8[i] <= q_s7[i];

				sin_s9[i] <= lfk_pkg::mulq(lfk_pkg::wide_t'(q_s8[i])
					* lfk_pkg::wide_t'({1'b0, ps_s8[i]}));
				cos_s9[i] <= lfk_pkg::q_t'(ONE_U - (mulu(t_s8[i], pc_s8[i]) >> 1));
			end
		end
	end

	assign ctrl_out = ctrl_s[TRIG_ST-1];
	assign sin_q = sin_s9;
	assign cos_q = cos_s9;

	// Every joint angle within bounds is below one radian, so cosine stays above one half.
	a_cos_floor: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s[TRIG_ST-1].valid && ctrl_s[TRIG_ST-1].in_range |->
			cos_s9[0] >= (lfk_pkg::ONE_Q >>> 1) && cos_s9[1] >= (lfk_pkg::ONE_Q >>> 1) &&
			cos_s9[2] >= (lfk_pkg::ONE_Q >>> 1))
		else $error("cosine below expected floor");

endmodule

// ----- design/lfk_pos.sv -----
// ----------------------------------------------------------------------------
// lfk_pos: leg geometry and output formatting
// Three stages: reach and height sums, hip products, rounding to Q10.8 with
// saturation and zeroing of poses outside the motor bounds.
// ----------------------------------------------------------------------------
module lfk_pos (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  lfk_pkg::ctrl_t ctrl_in,
	input  lfk_pkg::q_t    sin_q [lfk_pkg::NJ],
	input  lfk_pkg::q_t    cos_q [lfk_pkg::NJ],
	output lfk_pkg::ctrl_t ctrl_out,
	output lfk_pkg::foot_t foot_x,
	output lfk_pkg::foot_t foot_y,
	output lfk_pkg::foot_t foot_z
);

	localparam int POS_FRAC = 8;

	typedef logic signed [35:0] pos_t;
	typedef logic signed [63:0] lwide_t;

	localparam pos_t SAT_HI = pos_t'(2 ** (lfk_pkg::FOOT_W - 1) - 1);
	localparam pos_t SAT_LO = -pos_t'(2 ** (lfk_pkg::FOOT_W - 1));
	localparam pos_t HIP    = pos_t'(42) <<< lfk_pkg::QF;
	localparam pos_t REACH  = pos_t'(66) <<< lfk_pkg::QF;

	function automatic pos_t rmul(input lfk_pkg::q_t a, input pos_t b);
		return pos_t'((lwide_t'(a) * lwide_t'(b) + (lwide_t'(1) <<< (lfk_pkg::QF - 1)))
			>>> lfk_pkg::QF);
	endfunction

	function automatic lfk_pkg::foot_t to_pos(input pos_t v);
		pos_t r;
		r = (v + (pos_t'(1) <<< (lfk_pkg::QF - POS_FRAC - 1))) >>> (lfk_pkg::QF - POS_FRAC);
		if (r > SAT_HI) begin
			r = SAT_HI;
		end else if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return lfk_pkg::foot_t'(r);
	endfunction

	lfk_pkg::ctrl_t ctrl_s1, ctrl_s2, ctrl_s3;
	lfk_pkg::q_t    sb_s1, cb_s1;
	pos_t           r_s1, z_s1, x_s2, y_s2, z_s2;
	lfk_pkg::foot_t x_s3, y_s3, z_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= pos_t'(sin_q[1]) * pos_t'(75) + pos_t'(cos_q[2]) * pos_t'(32)
				+ pos_t'(cos_q[1]) * pos_t'(15) + REACH;
			z_s1 <= pos_t'(sin_q[2]) * pos_t'(32) + pos_t'(sin_q[1]) * pos_t'(15)
				- pos_t'(cos_q[1]) * pos_t'(75);
			sb_s1 <= sin_q[0];
			cb_s1 <= cos_q[0];

			x_s2 <= HIP - rmul(sb_s1, r_s1);
			y_s2 <= HIP + rmul(cb_s1, r_s1);
			z_s2 <= z_s1;

			x_s3 <= ctrl_s2.in_range ? to_pos(x_s2) : '0;
			y_s3 <= ctrl_s2.in_range ? to_pos(y_s2) : '0;
			z_s3 <= ctrl_s2.in_range ? to_pos(z_s2) : '0;
		end
	end

	assign ctrl_out = ctrl_s3;
	assign foot_x = x_s3;
	assign foot_y = y_s3;
	assign foot_z = z_s3;

endmodule

// ----- design/leg_forward_kinematics_unit.sv -----
// ----------------------------------------------------------------------------
// leg_forward_kinematics_unit: foot position from three servo angles
// Send one transaction on angle_in with the base, upper and lower servo
// angles (signed Q2.13 radians). One transaction comes back on foot_out with
// in_range and the foot position (signed Q10.8 mm, saturated); a pose with
// any angle outside its motor bounds returns in_range low and zero position.
// The datapath is a 17-stage pipeline: 5 stages for the servo-to-joint
// polynomials, 9 for the sine and cosine evaluation and 3 for the geometry
// and output rounding. A new pose is accepted every cycle while the output
// side keeps up. The whole pipeline advances together: when foot_out holds
// a result that the receiver does not take, every stage holds and
// angle_in.ready drops, so nothing is lost or repeated. Reset clears all
// valid flags, and the block is ready in the first cycle after reset is
// released.
// ----------------------------------------------------------------------------
module leg_forward_kinematics_unit (
	input  logic        clk,
	input  logic        arst_n,
	lfk_angle_if.sink   angle_in,
	lfk_foot_if.source  foot_out
);

	logic            en;
	lfk_pkg::angle_t angle [lfk_pkg::NJ];
	lfk_pkg::ctrl_t  joint_ctrl, trig_ctrl, pos_ctrl;
	lfk_pkg::q_t     q [lfk_pkg::NJ];
	lfk_pkg::q_t     sin_v [lfk_pkg::NJ];
	lfk_pkg::q_t     cos_v [lfk_pkg::NJ];

	assign en = !pos_ctrl.valid || foot_out.ready;
	assign angle_in.ready = en;

	assign angle[0] = angle_in.motor_angle_base;
	assign angle[1] = angle_in.motor_angle_upper;
	assign angle[2] = angle_in.motor_angle_lower;

	lfk_joint u_joint (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (angle_in.valid),
		.angle    (angle),
		.ctrl_out (joint_ctrl),
		.q        (q)
	);

	lfk_trig u_trig (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_in  (joint_ctrl),
		.q        (q),
		.ctrl_out (trig_ctrl),
		.sin_q    (sin_v),
		.cos_q    (cos_v)
	);

	lfk_pos u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_in  (trig_ctrl),
		.sin_q    (sin_v),
		.cos_q    (cos_v),
		.ctrl_out (pos_ctrl),
		.foot_x   (foot_out.foot_x),
		.foot_y   (foot_out.foot_y),
		.foot_z   (foot_out.foot_z)
	);

	assign foot_out.valid    = pos_ctrl.valid;
	assign foot_out.in_range = pos_ctrl.in_range;

	// A pose outside the motor bounds reports a zero position.
	a_zero_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		foot_out.valid && !foot_out.in_range |->
			foot_out.foot_x == '0 && foot_out.foot_y == '0 && foot_out.foot_z == '0)
		else $error("nonzero position for out-of-bounds pose");

	// A held result freezes the pipeline, so the input side is stalled too.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		foot_out.valid && !foot_out.ready |=> $stable(pos_ctrl) && $stable(trig_ctrl))
		else $error("pipeline moved during output stall");

endmodule

// ----- sim/tb_leg_forward_kinematics_unit.sv -----
// ----------------------------------------------------------------------------
// tb_leg_forward_kinematics_unit: self-checking testbench of the leg unit
// Sends servo poses on angle_in under several idle and stall patterns,
// predicts each foot position with an independent fixed-point model and
// compares every transaction on foot_out with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_leg_forward_kinematics_unit;

	typedef struct {
		logic           in_range;
		logic [18:0]    x;
		logic [18:0]    y;
		logic [18:0]    z;
	} foot_pos_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   hold_off;
	foot_pos_t pending_feet[$];

	lfk_angle_if angle_in ();
	lfk_foot_if  foot_out ();

	leg_forward_kinematics_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.angle_in (angle_in.sink),
		.foot_out (foot_out.source)
	);

	localparam longint ONE64 = 64'sd1 << 24;
	localparam longint BND_LO [3] = '{-6068, -5035, -12867};
	localparam longint BND_HI [3] = '{12867, 12867, 10199};
	localparam longint JPOLY [3][6] = '{
		'{-5975447, 14582336, -232683, 6136104, 846134, -1302618},
		'{-7294442, 15427689, 2751231, 6701209, 838093, -1294457},
		'{2010752, 11960792, 837335, 11748947, -41406, 2760006}
	};

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return round_shift(a * b, 24);
	endfunction

	function automatic longint fx_sin(longint q);
		longint t, p;
		t = fx_mul(q, q);
		p = ONE64;
		p = ONE64 - fx_mul(t, p) / 72;
		p = ONE64 - fx_mul(t, p) / 42;
		p = ONE64 - fx_mul(t, p) / 20;
		p = ONE64 - fx_mul(t, p) / 6;
		return fx_mul(q, p);
	endfunction

	function automatic longint fx_cos(longint q);
		longint t, p;
		t = fx_mul(q, q);
		p = ONE64;
		p = ONE64 - fx_mul(t, p) / 90;
		p = ONE64 - fx_mul(t, p) / 56;
		p = ONE64 - fx_mul(t, p) / 30;
		p = ONE64 - fx_mul(t, p) / 12;
		p = ONE64 - fx_mul(t, p) / 2;
		return p;
	endfunction

	function automatic logic [18:0] to_foot(longint v);
		longint r;
		r = round_shift(v, 16);
		if (r > 262143) r = 262143;
		if (r < -262144) r = -262144;
		return r[18:0];
	endfunction

	function automatic foot_pos_t predict_foot(lfk_pkg::angle_t ab, lfk_pkg::angle_t au,
		lfk_pkg::angle_t al);
		foot_pos_t f;
		longint a[3];
		longint q[3];
		longint u, u2, u3, sb, cb, su, cu, sl, cl, r;
		a[0] = ab;
		a[1] = au;
		a[2] = al;
		f = '{1'b0, '0, '0, '0};
		for (int i = 0; i < 3; i++) begin
			if (a[i] < BND_LO[i] || a[i] > BND_HI[i]) begin
				return f;
			end
			u = JPOLY[i][0] + round_shift(JPOLY[i][1] * a[i], 13);
			u2 = fx_mul(u, u);
			u3 = fx_mul(u2, u);
			q[i] = JPOLY[i][2] + fx_mul(JPOLY[i][3], u) + fx_mul(JPOLY[i][4], u2)
				+ fx_mul(JPOLY[i][5], u3);
		end
		sb = fx_sin(q[0]);
		cb = fx_cos(q[0]);
		su = fx_sin(q[1]);
		cu = fx_cos(q[1]);
		sl = fx_sin(q[2]);
		cl = fx_cos(q[2]);
		r = 75 * su + 32 * cl + 15 * cu + 66 * ONE64;
		f.in_range = 1'b1;
		f.x = to_foot(42 * ONE64 - fx_mul(sb, r));
		f.y = to_foot(42 * ONE64 + fx_mul(cb, r));
		f.z = to_foot(32 * sl + 15 * su - 75 * cu);
		return f;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("Mismatch on %s: got %0d, expected %0d", what, got, want);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			foot_out.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			foot_out.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		foot_pos_t want;
		if (arst_n && foot_out.valid && foot_out.ready) begin
			if (pending_feet.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				want = pending_feet.pop_front();
				if (foot_out.in_range !== want.in_range)
					report_mismatch("in_range", foot_out.in_range, want.in_range);
				if (foot_out.foot_x !== want.x)
					report_mismatch("foot_x", foot_out.foot_x, $signed(want.x));
				if (foot_out.foot_y !== want.y)
					report_mismatch("foot_y", foot_out.foot_y, $signed(want.y));
				if (foot_out.foot_z !== want.z)
					report_mismatch("foot_z", foot_out.foot_z, $signed(want.z));
			end
		end
	end

	task automatic send_pose(lfk_pkg::angle_t ab, lfk_pkg::angle_t au, lfk_pkg::angle_t al);
		while ($urandom_range(99) < send_idle_pct) begin
			angle_in.valid <= 1'b0;
			@(posedge clk);
		end
		angle_in.valid <= 1'b1;
		angle_in.motor_angle_base <= ab;
		angle_in.motor_angle_upper <= au;
		angle_in.motor_angle_lower <= al;
		do @(posedge clk); while (!angle_in.ready);
		pending_feet.push_back(predict_foot(ab, au, al));
	endtask

	function automatic lfk_pkg::angle_t pick_angle(int j);
		int r;
		r = $urandom_range(9);
		if (r == 0) return lfk_pkg::angle_t'($urandom);
		if (r == 1) return lfk_pkg::angle_t'(BND_LO[j] - $urandom_range(1, 3));
		if (r == 2) return lfk_pkg::angle_t'(BND_HI[j] + $urandom_range(1, 3));
		return lfk_pkg::angle_t'($urandom_range(BND_HI[j] - BND_LO[j]) + BND_LO[j]);
	endfunction

	task automatic test_directed();
		send_pose(lfk_pkg::angle_t'(BND_LO[0]), lfk_pkg::angle_t'(BND_LO[1]),
			lfk_pkg::angle_t'(BND_LO[2]));
		send_pose(lfk_pkg::angle_t'(BND_HI[0]), lfk_pkg::angle_t'(BND_HI[1]),
			lfk_pkg::angle_t'(BND_HI[2]));
		send_pose(16'sd0, 16'sd0, 16'sd0);
		send_pose(lfk_pkg::angle_t'(BND_LO[0] - 1), 16'sd0, 16'sd0);
		send_pose(lfk_pkg::angle_t'(BND_HI[0] + 1), 16'sd0, 16'sd0);
		send_pose(16'sd0, lfk_pkg::angle_t'(BND_LO[1] - 1), 16'sd0);
		send_pose(16'sd0, lfk_pkg::angle_t'(BND_HI[1] + 1), 16'sd0);
		send_pose(16'sd0, 16'sd0, lfk_pkg::angle_t'(BND_LO[2] - 1));
		send_pose(16'sd0, 16'sd0, lfk_pkg::angle_t'(BND_HI[2] + 1));
		send_pose(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_pose(-16'sd32768, -16'sd32768, -16'sd32768);
		send_pose(lfk_pkg::angle_t'(BND_HI[0]), lfk_pkg::angle_t'(BND_LO[1]),
			lfk_pkg::angle_t'(BND_HI[2]));
		send_pose(lfk_pkg::angle_t'(BND_LO[0]), lfk_pkg::angle_t'(BND_HI[1]),
			lfk_pkg::angle_t'(BND_LO[2]));
		send_pose(16'sh5555, 16'shaaaa, 16'sh1234);
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_pose(pick_angle(0), pick_angle(1), pick_angle(2));
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off <= 200;
		repeat (60) send_pose(pick_angle(0), pick_angle(1), pick_angle(2));
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_off = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		angle_in.valid = 1'b0;
		angle_in.motor_angle_base = '0;
		angle_in.motor_angle_upper = '0;
		angle_in.motor_angle_lower = '0;
		foot_out.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(320, 0, 0);
		test_random(320, 67, 0);
		test_random(320, 0, 67);
		test_random(320, 34, 34);
		test_backpressure();
		angle_in.valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_feet.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
